// File: src/binary_to_decimal_ascii_assert.svh
// Assertion macros used by the converter's top-level RTL.
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B2DA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("binary_to_decimal_ascii: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define B2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("binary_to_decimal_ascii: assertion failed");

`endif

// File: src/b2da_pkg.sv
package b2da_pkg;

	// Width of the binary input and of one BCD digit.
	localparam int VALUE_W        = 64;
	localparam int BCD_W          = 4;
	localparam int CHAR_W         = 6;
	localparam int MAX_DIGITS_DEF = 20;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

	// Operation applied to every cell of the digit chain in one cycle.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_DABBLE,
		CELL_SHIFT
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	function automatic logic [CHAR_W-1:0] bcd_to_ascii(input logic [BCD_W-1:0] d);
		return ASCII_ZERO + CHAR_W'(d);
	endfunction

endpackage

// File: src/b2da_cell.sv
module b2da_cell (
	input  logic                      clk,
	input  b2da_pkg::cell_op_t        op,
	input  logic                      carry_in,
	input  logic [b2da_pkg::BCD_W-1:0] digit_in,
	output logic                      carry_out,
	output logic [b2da_pkg::BCD_W-1:0] digit
);
	import b2da_pkg::*;

	logic [BCD_W-1:0] digit_q;
	logic [BCD_W-1:0] adj;

	// Add three to a digit of five or more so that the shift carries at ten.
	assign adj       = (digit_q >= BCD_W'(5)) ? digit_q + BCD_W'(3) : digit_q;
	assign carry_out = adj[BCD_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_HOLD:   digit_q <= digit_q;
			CELL_CLEAR:  digit_q <= '0;
			CELL_DABBLE: digit_q <= {adj[BCD_W-2:0], carry_in};
			CELL_SHIFT:  digit_q <= digit_in;
			default:     digit_q <= digit_q;
		endcase
	end

endmodule

// File: src/binary_to_decimal_ascii.sv
// Channel   Ports                        Handshake
// --------  ---------------------------  ------------------------------------
// input     value[63:0]                  taken when start is high, busy low
// result    digit_char[5:0], last        shown for one cycle with digit_valid
//
// An item is loaded, then shifted and adjusted once for each of the 64 input
// bits through the chain of 20 BCD cells, and then the chain shifts towards
// its top cell once for each cell; leading zeros are shifted past without a
// strobe, so the time per item does not depend on the value, and a new item
// is taken only once the previous one has been fully emitted. The pass over
// the 64 input bits takes the bulk of that time. Reset clears the controller
// and the result strobe; the cell digits are cleared on each accepted item.
// The receiver cannot stall: each result is on the ports for one cycle.
module binary_to_decimal_ascii #(
	parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [b2da_pkg::VALUE_W-1:0] value,
	output logic                         digit_valid,
	output logic [b2da_pkg::CHAR_W-1:0]  digit_char,
	output logic                         last
);
	import b2da_pkg::*;

	localparam int BIT_CNT_W = $clog2(VALUE_W);
	localparam int REM_W     = $clog2(MAX_DIGITS + 1);

	// Controller state.
	state_t               state_q, state_d;
	logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
	logic [REM_W-1:0]     remain_q, remain_d;
	logic                 started_q, started_d;

	// The binary value is shifted out of its top bit into the bottom cell.
	logic [VALUE_W-1:0]   value_q, value_d;

	// Result register.
	logic                 digit_valid_q, digit_valid_d;
	logic [CHAR_W-1:0]    digit_char_q, digit_char_d;
	logic                 last_q, last_d;

	// The digit chain: cell 0 holds the least significant decimal digit.
	cell_op_t             cell_op;
	logic [BCD_W-1:0]     cell_digit [MAX_DIGITS];
	logic [MAX_DIGITS-1:0] cell_carry;
	logic [BCD_W-1:0]     top_digit;

	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		logic             cin;
		logic [BCD_W-1:0] din;
		if (i == 0) begin : g_first
			assign cin = value_q[VALUE_W-1];
			assign din = '0;
		end else begin : g_rest
			assign cin = cell_carry[i-1];
			assign din = cell_digit[i-1];
		end
		b2da_cell u_cell (
			.clk       (clk),
			.op        (cell_op),
			.carry_in  (cin),
			.digit_in  (din),
			.carry_out (cell_carry[i]),
			.digit     (cell_digit[i])
		);
	end

	assign top_digit = cell_digit[MAX_DIGITS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			bit_cnt_q     <= '0;
			remain_q      <= '0;
			started_q     <= 1'b0;
			digit_valid_q <= 1'b0;
		end else begin
			state_q       <= state_d;
			bit_cnt_q     <= bit_cnt_d;
			remain_q      <= remain_d;
			started_q     <= started_d;
			digit_valid_q <= digit_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q      <= value_d;
		digit_char_q <= digit_char_d;
		last_q       <= last_d;
	end

	// Next state. During emission the chain shifts one place a cycle towards
	// the top cell, which is read out; leading zeros are dropped until either
	// a non-zero digit appears or only the units digit is left, so that a zero
	// value still gives a single '0'.
	always_comb begin
		state_d       = state_q;
		bit_cnt_d     = bit_cnt_q;
		remain_d      = remain_q;
		started_d     = started_q;
		value_d       = value_q;
		digit_valid_d = 1'b0;
		digit_char_d  = digit_char_q;
		last_d        = last_q;
		cell_op       = CELL_HOLD;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cell_op   = CELL_CLEAR;
					value_d   = value;
					bit_cnt_d = '0;
					state_d   = ST_CONV;
				end
			end
			ST_CONV: begin
				cell_op   = CELL_DABBLE;
				value_d   = {value_q[VALUE_W-2:0], 1'b0};
				bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
				if (bit_cnt_q == BIT_CNT_W'(VALUE_W - 1)) begin
					remain_d  = REM_W'(MAX_DIGITS);
					started_d = 1'b0;
					state_d   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cell_op  = CELL_SHIFT;
				remain_d = remain_q - REM_W'(1);
				if (started_q || top_digit != '0 || remain_q == REM_W'(1)) begin
					digit_valid_d = 1'b1;
					digit_char_d  = bcd_to_ascii(top_digit);
					last_d        = (remain_q == REM_W'(1));
					started_d     = 1'b1;
					if (remain_q == REM_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign digit_valid = digit_valid_q;
	assign digit_char  = digit_char_q;
	assign last        = last_q;

	`include "binary_to_decimal_ascii_assert.svh"

	// An accepted item always makes the block busy on the next cycle.
	`B2DA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// The final digit of a run is never followed directly by another digit.
	`B2DA_ASSERT_NEXT(a_last_ends_run, clk, arst_n, digit_valid && last, !digit_valid)
	// A digit that is not the last leaves the converter still emitting.
	`B2DA_ASSERT_NOW(a_run_busy, clk, arst_n, digit_valid && !last, busy)
	// Every emitted character is a decimal digit.
	`B2DA_ASSERT_NOW(a_char_range, clk, arst_n, digit_valid,
		digit_char >= ASCII_ZERO && digit_char <= ASCII_ZERO + CHAR_W'(9))

endmodule

// File: test/b2da_digit_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the converter, works out the decimal digits of
// every accepted value and compares each strobed character against them.
module b2da_digit_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic [b2da_pkg::VALUE_W-1:0] value,
	input  logic                         digit_valid,
	input  logic [b2da_pkg::CHAR_W-1:0]  digit_char,
	input  logic                         last,
	output int                           fails,
	output int                           digits_waiting,
	output int                           digits_seen
);

	import b2da_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} digit_t;

	digit_t pending_digits[$];

	// Splits the value into decimal digits by repeated division and queues
	// them most significant first, the final one flagged as last.
	function automatic void predict_run(input logic [VALUE_W-1:0] v);
		bit [VALUE_W-1:0] rest;
		bit [BCD_W-1:0]   digs[MAX_DIGITS_DEF];
		int               n;
		digit_t           d;
		rest = v;
		n    = 0;
		do begin
			digs[n] = BCD_W'(rest % 10);
			rest    = rest / 10;
			n++;
		end while (rest != 0);
		for (int i = n - 1; i >= 0; i--) begin
			d.ch   = ASCII_ZERO + CHAR_W'(digs[i]);
			d.last = (i == 0);
			pending_digits.push_back(d);
		end
	endfunction

	initial begin
		fails          = 0;
		digits_seen    = 0;
		digits_waiting = 0;
	end

	always @(posedge clk) begin
		digit_t want;
		if (arst_n) begin
			if (digit_valid) begin
				digits_seen++;
				if (pending_digits.size() == 0) begin
					$error("digit_char %0d arrived with no digit expected", digit_char);
					fails++;
				end else begin
					want = pending_digits.pop_front();
					if (digit_char !== want.ch) begin
						$error("digit_char: expected %0d, got %0d", want.ch, digit_char);
						fails++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						fails++;
					end
				end
			end
			if (start && !busy)
				predict_run(value);
		end
		digits_waiting = pending_digits.size();
	end

endmodule

// File: test/tb_binary_to_decimal_ascii.sv
`timescale 1ns / 100ps

// Top of the converter's testbench. It only makes stimulus and gives the
// verdict: the checker beside the block predicts every digit and counts the
// failures. Inputs are driven at the falling edge of the clock and all
// sampling is done at the rising edge, so nothing depends on the order of
// events within one time step.
module tb_binary_to_decimal_ascii;

	import b2da_pkg::*;

	// Cycles in which neither an item nor a digit is accepted before the run
	// is given up. It must exceed the quiet stretch of the slowest correct item
	// together with the sender's random gaps.
	localparam int WATCHDOG_LIMIT = 2000;
	// Cycles allowed after the last expected digit for anything stray to show.
	localparam int TAIL_CYCLES    = 100;
	localparam int RANDOM_ITEMS   = 260;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [VALUE_W-1:0]   value;
	logic                 digit_valid;
	logic [CHAR_W-1:0]    digit_char;
	logic                 last;

	int                   fails;
	int                   digits_waiting;
	int                   digits_seen;
	int                   items_sent;
	int                   idle_pct;
	int                   quiet_cycles;
	logic [VALUE_W-1:0]   ten_power[MAX_DIGITS_DEF];

	always #1 clk = ~clk;

	binary_to_decimal_ascii u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.digit_valid (digit_valid),
		.digit_char  (digit_char),
		.last        (last)
	);

	b2da_digit_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.value          (value),
		.digit_valid    (digit_valid),
		.digit_char     (digit_char),
		.last           (last),
		.fails          (fails),
		.digits_waiting (digits_waiting),
		.digits_seen    (digits_seen)
	);

	// Offers one item. Before it, the sender may sit idle at random, and
	// meanwhile the value bus carries noise that must be ignored. Start is
	// then held high until a rising edge finds busy low; busy read straight
	// after the edge still holds its value from before the edge.
	task automatic offer_value(input logic [VALUE_W-1:0] v);
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			value <= {$urandom, $urandom};
		end
		@(negedge clk);
		start <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (busy);
		items_sent++;
	endtask

	// Random values come in several shapes so that short runs, full 20-digit
	// runs and the edges around every power of ten are all reached often.
	function automatic logic [VALUE_W-1:0] random_value();
		logic [VALUE_W-1:0] raw;
		int                 width;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return raw;
			1: begin
				width = $urandom_range(0, VALUE_W);
				if (width == VALUE_W)
					return raw;
				return raw & ((64'd1 << width) - 64'd1);
			end
			2: return ten_power[$urandom_range(0, MAX_DIGITS_DEF - 1)]
				+ VALUE_W'($urandom_range(0, 4)) - 64'd2;
			default: return raw >> $urandom_range(0, VALUE_W - 1);
		endcase
	endfunction

	// The watchdog counts cycles in which nothing at all is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || digit_valid)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[binary_to_decimal_ascii] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		value        = '0;
		items_sent   = 0;
		quiet_cycles = 0;
		idle_pct     = 16;
		ten_power[0] = 64'd1;
		for (int i = 1; i < MAX_DIGITS_DEF; i++)
			ten_power[i] = ten_power[i-1] * 64'd10;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: zero, which must give a lone '0', the largest value,
		// which gives the full twenty digits, the smallest twenty-digit value,
		// both sides of several powers of ten and values that use every digit.
		offer_value(64'd0);
		offer_value(64'd1);
		offer_value(64'd9);
		offer_value(64'd10);
		offer_value(64'd99);
		offer_value(64'd100);
		offer_value(64'd1234567890);
		offer_value(64'd9876543210);
		offer_value(64'hFFFF_FFFF);
		offer_value(64'h1_0000_0000);
		offer_value(64'd9999999999999999999);
		offer_value(64'd10000000000000000000);
		offer_value(64'h7FFF_FFFF_FFFF_FFFF);
		offer_value(64'h8000_0000_0000_0000);
		offer_value(64'hFFFF_FFFF_FFFF_FFFE);
		offer_value(64'hFFFF_FFFF_FFFF_FFFF);
		offer_value(64'hAAAA_AAAA_AAAA_AAAA);
		offer_value(64'h5555_5555_5555_5555);

		// Random part in three stretches: the sender idles lightly, then
		// heavily, then not at all so that items follow back to back. The
		// receiver has no way to stall, so only the sender's pace varies.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3)
				idle_pct = 60;
			else if (i == 2 * RANDOM_ITEMS / 3)
				idle_pct = 0;
			offer_value(random_value());
		end
		@(negedge clk);
		start <= 1'b0;

		// Wait for every predicted digit, then a little longer in case the
		// block sends anything it should not. The watchdog bounds the wait.
		while (digits_waiting != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Converted %0d values to text and checked %0d digit characters,",
			items_sent, digits_seen);
		$display("with light, heavy and no sender idling; %0d mismatches.", fails);
		if (fails == 0)
			$display("[binary_to_decimal_ascii] OK");
		else
			$display("[binary_to_decimal_ascii] ERROR");
		$finish;
	end

endmodule
